/* hw/rtl/pfc_pkg.sv */
package pfc_pkg;

    localparam int unsigned SIDE  = 5;
    localparam int unsigned CELLS = 25;
    localparam int unsigned ALPHA = 26;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] place_t;
    typedef logic [2:0] coord_t;

    localparam letter_t LET_I = 5'd8;
    localparam letter_t LET_J = 5'd9;
    localparam letter_t LET_X = 5'd23;
    localparam letter_t LET_LAST = 5'd25;     // 'z'
    localparam place_t  CELLS_P = 5'd25;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_KEY    = 3'd1;
    localparam logic [2:0] OP_FINISH = 3'd2;
    localparam logic [2:0] OP_TEXT   = 3'd3;
    localparam logic [2:0] OP_END    = 3'd4;

    // p / 5 for p < 25 via multiply by 13 and shift by 6
    function automatic coord_t row_of(input place_t p);
        logic [8:0] prod;
        prod = {4'b0000, p} * 9'd13;
        return prod[8:6];
    endfunction

    function automatic place_t place_of(input coord_t r, input coord_t c);
        return {r[2:0], 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    function automatic coord_t col_of(input place_t p);
        place_t base;
        base = place_of(row_of(p), 3'd0);
        return coord_t'(p - base);
    endfunction

    // (c + sh) mod 5, with c < 5 and sh < 5
    function automatic coord_t wrap_add(input coord_t c, input coord_t sh);
        logic [3:0] sum;
        sum = {1'b0, c} + {1'b0, sh};
        if (sum >= 4'd5) begin
            sum = sum - 4'd5;
        end
        return sum[2:0];
    endfunction

endpackage

/* hw/rtl/playfair_digraph_cipher_unit.sv */
// Playfair cipher over a 5x5 square. Load the key with clear, key letters
// and finish, then stream text letters and an end-of-text marker; direction
// (encrypt with x padding, or decrypt) must be written by the user only while
// idle; the block itself does not enforce this. Finish walks the alphabet
// through the single write port of the square. A text letter that completes a
// pair passes the states RDA, RDB, CALC, SQA and SQB before its two results
// are given out in OUTA and OUTB, since the one-read-per-cycle place map and
// square memories are read one after the other. The input is ready again as
// soon as the last result sits in the output register.
module playfair_digraph_cipher_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_opcode,
    input  logic [4:0] s_letter,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_out_letter,
    output logic       m_last,
    output logic       m_error
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_FILL, ST_ERR, ST_RDA, ST_RDB, ST_CALC,
        ST_SQA, ST_SQB, ST_OUTA, ST_OUTB
    } state_t;

    state_t state_reg;

    logic            dir_reg;
    logic [25:0]     used_mask_reg;
    pfc_pkg::place_t fill_count_reg;
    logic            key_ready_reg;
    pfc_pkg::letter_t held_letter_reg;
    logic            held_valid_reg;
    pfc_pkg::letter_t walk_reg;
    pfc_pkg::letter_t pair_a_reg, pair_b_reg;
    pfc_pkg::place_t pa_reg, oa_reg, ob_reg;
    pfc_pkg::letter_t res_a_reg;

    logic            m_valid_reg;
    logic [4:0]      m_out_letter_reg;
    logic            m_last_reg;
    logic            m_error_reg;

    pfc_pkg::letter_t square_mem [pfc_pkg::CELLS];
    pfc_pkg::place_t  place_mem  [pfc_pkg::ALPHA];
    pfc_pkg::letter_t sq_rd_reg;
    pfc_pkg::place_t  place_rd_reg;

    logic            accept;
    logic            out_free;
    logic            let_ok;
    logic [31:0]     used_ext;
    pfc_pkg::letter_t text_let;
    logic            key_take;
    logic            fill_take;
    logic            mem_we;
    pfc_pkg::letter_t mem_wletter;
    pfc_pkg::letter_t place_raddr;
    pfc_pkg::place_t sq_raddr;
    pfc_pkg::place_t calc_oa, calc_ob;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_out_letter = m_out_letter_reg;
    assign m_last       = m_last_reg;
    assign m_error      = m_error_reg;

    assign used_ext = {6'b000000, used_mask_reg};
    assign let_ok   = (s_letter <= pfc_pkg::LET_LAST);
    assign text_let = (s_letter == pfc_pkg::LET_J) ? pfc_pkg::LET_I : s_letter;

    assign key_take = accept && (s_opcode == pfc_pkg::OP_KEY) && !key_ready_reg && let_ok
                      && (s_letter != pfc_pkg::LET_J) && !used_ext[s_letter]
                      && (fill_count_reg < pfc_pkg::CELLS_P);
    assign fill_take = (state_reg == ST_FILL) && (walk_reg != pfc_pkg::LET_J)
                       && !used_ext[walk_reg] && (fill_count_reg < pfc_pkg::CELLS_P);
    assign mem_we      = key_take || fill_take;
    assign mem_wletter = (state_reg == ST_FILL) ? walk_reg : s_letter;

    assign place_raddr = (state_reg == ST_RDA) ? pair_a_reg : pair_b_reg;
    assign sq_raddr    = (state_reg == ST_SQA) ? oa_reg : ob_reg;

    pfc_pair_rule u_pair_rule (
        .pos_a     (pa_reg),
        .pos_b     (place_rd_reg),
        .decrypt   (dir_reg),
        .out_pos_a (calc_oa),
        .out_pos_b (calc_ob)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            square_mem[fill_count_reg] <= mem_wletter;
            place_mem[mem_wletter]     <= fill_count_reg;
        end
        sq_rd_reg    <= square_mem[sq_raddr];
        place_rd_reg <= place_mem[place_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            dir_reg         <= 1'b0;
            used_mask_reg   <= '0;
            fill_count_reg  <= '0;
            key_ready_reg   <= 1'b0;
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            walk_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                dir_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (mem_we) begin
                fill_count_reg <= fill_count_reg + 5'd1;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (s_opcode)
                            pfc_pkg::OP_CLEAR: begin
                                used_mask_reg  <= '0;
                                fill_count_reg <= '0;
                                key_ready_reg  <= 1'b0;
                                held_valid_reg <= 1'b0;
                            end
                            pfc_pkg::OP_KEY: begin
                                if (key_take) begin
                                    used_mask_reg <= used_mask_reg | 26'(32'd1 << s_letter);
                                end
                            end
                            pfc_pkg::OP_FINISH: begin
                                if (!key_ready_reg) begin
                                    walk_reg  <= '0;
                                    state_reg <= ST_FILL;
                                end
                            end
                            pfc_pkg::OP_TEXT: begin
                                if (let_ok) begin
                                    if (!key_ready_reg) begin
                                        state_reg <= ST_ERR;
                                    end else if (!held_valid_reg) begin
                                        held_letter_reg <= text_let;
                                        held_valid_reg  <= 1'b1;
                                    end else begin
                                        pair_a_reg <= held_letter_reg;
                                        state_reg  <= ST_RDA;
                                        if (!dir_reg && (held_letter_reg == text_let)) begin
                                            // repeat: pad with x, keep the new letter held
                                            pair_b_reg      <= pfc_pkg::LET_X;
                                            held_letter_reg <= text_let;
                                        end else begin
                                            pair_b_reg     <= text_let;
                                            held_valid_reg <= 1'b0;
                                        end
                                    end
                                end
                            end
                            pfc_pkg::OP_END: begin
                                if (key_ready_reg && held_valid_reg) begin
                                    held_valid_reg <= 1'b0;
                                    if (dir_reg) begin
                                        state_reg <= ST_ERR;
                                    end else begin
                                        pair_a_reg <= held_letter_reg;
                                        pair_b_reg <= pfc_pkg::LET_X;
                                        state_reg  <= ST_RDA;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_FILL: begin
                    if (walk_reg != pfc_pkg::LET_J) begin
                        used_mask_reg <= used_mask_reg | 26'(32'd1 << walk_reg);
                    end
                    if (walk_reg == pfc_pkg::LET_LAST) begin
                        key_ready_reg  <= 1'b1;
                        held_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end else begin
                        walk_reg <= walk_reg + 5'd1;
                    end
                end
                ST_ERR: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_out_letter_reg <= '0;
                        m_last_reg       <= 1'b1;
                        m_error_reg      <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                ST_RDA: begin
                    state_reg <= ST_RDB;
                end
                ST_RDB: begin
                    pa_reg    <= place_rd_reg;
                    state_reg <= ST_CALC;
                end
                ST_CALC: begin
                    oa_reg    <= calc_oa;
                    ob_reg    <= calc_ob;
                    state_reg <= ST_SQA;
                end
                ST_SQA: begin
                    state_reg <= ST_SQB;
                end
                ST_SQB: begin
                    res_a_reg <= sq_rd_reg;
                    state_reg <= ST_OUTA;
                end
                ST_OUTA: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_out_letter_reg <= res_a_reg;
                        m_last_reg       <= 1'b0;
                        m_error_reg      <= 1'b0;
                        state_reg        <= ST_OUTB;
                    end
                end
                ST_OUTB: begin
                    // square read of the second place holds while ob stays addressed
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_out_letter_reg <= sq_rd_reg;
                        m_last_reg       <= 1'b1;
                        m_error_reg      <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/pfc_pair_rule.sv */
module pfc_pair_rule (
    input  pfc_pkg::place_t pos_a,
    input  pfc_pkg::place_t pos_b,
    input  logic            decrypt,
    output pfc_pkg::place_t out_pos_a,
    output pfc_pkg::place_t out_pos_b
);

    pfc_pkg::coord_t ra, ca, rb, cb, sh;

    assign ra = pfc_pkg::row_of(pos_a);
    assign ca = pfc_pkg::col_of(pos_a);
    assign rb = pfc_pkg::row_of(pos_b);
    assign cb = pfc_pkg::col_of(pos_b);
    assign sh = decrypt ? 3'd4 : 3'd1;

    always_comb begin
        if (ra == rb) begin
            out_pos_a = pfc_pkg::place_of(ra, pfc_pkg::wrap_add(ca, sh));
            out_pos_b = pfc_pkg::place_of(rb, pfc_pkg::wrap_add(cb, sh));
        end else if (ca == cb) begin
            out_pos_a = pfc_pkg::place_of(pfc_pkg::wrap_add(ra, sh), ca);
            out_pos_b = pfc_pkg::place_of(pfc_pkg::wrap_add(rb, sh), cb);
        end else begin
            // rectangle: swap columns
            out_pos_a = pfc_pkg::place_of(ra, cb);
            out_pos_b = pfc_pkg::place_of(rb, ca);
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam logic [2:0]       OP_UNUSED    = 3'd7;
    localparam pfc_pkg::letter_t BAD_LETTER   = 5'd31;
    localparam int               DRAIN_CYCLES = 40;
    localparam int               HOLD_CYCLES  = 300;
    localparam int               QUIET_LIMIT  = 2000;
    localparam int               RANDOM_ITEMS = 1950;

    typedef struct packed {
        pfc_pkg::letter_t ch;
        logic             last;
        logic             err;
    } result_t;

    typedef struct packed {
        logic             dir;
        logic [2:0]       op;
        pfc_pkg::letter_t ch;
        logic             typed;     // expectation written out below
        logic [1:0]       n_typed;
        result_t          r_typed;
    } step_t;

    localparam result_t NO_RESULT  = '{5'd0, 1'b0, 1'b0};
    localparam result_t ERR_RESULT = '{5'd0, 1'b1, 1'b1};
    localparam int      NUM_STEPS  = 26;

    localparam step_t SCRIPT [NUM_STEPS] = '{
        '{1'b0, pfc_pkg::OP_TEXT,   5'd0,              1'b1, 2'd1, ERR_RESULT},
        '{1'b0, pfc_pkg::OP_END,    5'd0,              1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_KEY,    pfc_pkg::LET_J,    1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_KEY,    pfc_pkg::LET_LAST, 1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_KEY,    5'd0,              1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_KEY,    pfc_pkg::LET_LAST, 1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_KEY,    BAD_LETTER,        1'b1, 2'd0, NO_RESULT},
        '{1'b0, OP_UNUSED,          BAD_LETTER,        1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_FINISH, 5'd0,              1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_KEY,    5'd1,              1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_FINISH, 5'd0,              1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_TEXT,   BAD_LETTER,        1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_TEXT,   pfc_pkg::LET_X,    1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_TEXT,   pfc_pkg::LET_X,    1'b0, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_END,    5'd0,              1'b0, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_TEXT,   pfc_pkg::LET_J,    1'b1, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_TEXT,   pfc_pkg::LET_I,    1'b0, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_TEXT,   pfc_pkg::LET_LAST, 1'b0, 2'd0, NO_RESULT},
        '{1'b0, pfc_pkg::OP_TEXT,   5'd0,              1'b1, 2'd0, NO_RESULT},
        '{1'b1, pfc_pkg::OP_TEXT,   5'd1,              1'b0, 2'd0, NO_RESULT},
        '{1'b1, pfc_pkg::OP_TEXT,   5'd2,              1'b1, 2'd0, NO_RESULT},
        '{1'b1, pfc_pkg::OP_END,    5'd0,              1'b1, 2'd1, ERR_RESULT},
        '{1'b1, pfc_pkg::OP_TEXT,   5'd3,              1'b1, 2'd0, NO_RESULT},
        '{1'b1, pfc_pkg::OP_TEXT,   5'd3,              1'b0, 2'd0, NO_RESULT},
        '{1'b1, pfc_pkg::OP_CLEAR,  5'd0,              1'b1, 2'd0, NO_RESULT},
        '{1'b1, pfc_pkg::OP_TEXT,   5'd4,              1'b1, 2'd1, ERR_RESULT}
    };

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [2:0] s_opcode    = pfc_pkg::OP_CLEAR;
    logic [4:0] s_letter    = 5'd0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [4:0] m_out_letter;
    logic       m_last;
    logic       m_error;

    // cipher state mirror
    pfc_pkg::letter_t         sq_model [pfc_pkg::CELLS];
    pfc_pkg::place_t          at_model [pfc_pkg::ALPHA];
    logic [pfc_pkg::ALPHA-1:0] used_model = '0;
    logic [4:0]               fill_model = '0;
    logic                     key_done   = 1'b0;
    logic                     held_vld   = 1'b0;
    pfc_pkg::letter_t         held_let   = '0;
    logic                     dir_model  = 1'b0;

    result_t cipher_q [$];
    result_t head_r;

    int errors        = 0;
    int sent_items    = 0;
    int ignored_items = 0;
    int results_seen  = 0;
    int pairs_seen    = 0;
    int err_results   = 0;
    int tx_idle_pct   = 18;
    int rx_idle_pct   = 73;
    int hold_asked    = 0;
    int hold_given    = 0;
    int hold_cnt      = 0;
    int quiet         = 0;

    playfair_digraph_cipher_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_letter     (s_letter),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_letter (m_out_letter),
        .m_last       (m_last),
        .m_error      (m_error)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void add_to_square(input pfc_pkg::letter_t l);
        if (fill_model < pfc_pkg::CELLS) begin
            sq_model[fill_model] = l;
            at_model[l] = fill_model;
            fill_model++;
        end
        used_model[l] = 1'b1;
    endfunction

    function automatic void map_pair(input pfc_pkg::letter_t a, input pfc_pkg::letter_t b,
                                     output result_t ra_o, output result_t rb_o);
        int pa, pb, row_a, col_a, row_b, col_b, shift, oa, ob;
        pa = at_model[a];
        pb = at_model[b];
        row_a = pa / pfc_pkg::SIDE;
        col_a = pa % pfc_pkg::SIDE;
        row_b = pb / pfc_pkg::SIDE;
        col_b = pb % pfc_pkg::SIDE;
        shift = dir_model ? pfc_pkg::SIDE - 1 : 1;
        if (row_a == row_b) begin
            oa = row_a * pfc_pkg::SIDE + (col_a + shift) % pfc_pkg::SIDE;
            ob = row_b * pfc_pkg::SIDE + (col_b + shift) % pfc_pkg::SIDE;
        end else if (col_a == col_b) begin
            oa = ((row_a + shift) % pfc_pkg::SIDE) * pfc_pkg::SIDE + col_a;
            ob = ((row_b + shift) % pfc_pkg::SIDE) * pfc_pkg::SIDE + col_b;
        end else begin
            oa = row_a * pfc_pkg::SIDE + col_b;
            ob = row_b * pfc_pkg::SIDE + col_a;
        end
        ra_o = '{sq_model[oa], 1'b0, 1'b0};
        rb_o = '{sq_model[ob], 1'b1, 1'b0};
    endfunction

    // advance the mirror by one transaction; returns the number of results
    function automatic int cipher_step(input logic [2:0] op, input pfc_pkg::letter_t ch,
                                       output result_t r0, output result_t r1,
                                       output logic acted);
        pfc_pkg::letter_t c;
        int n;
        n = 0;
        acted = 1'b1;
        r0 = NO_RESULT;
        r1 = NO_RESULT;
        c = ch;
        case (op)
            pfc_pkg::OP_CLEAR: begin
                used_model = '0;
                fill_model = '0;
                key_done = 1'b0;
                held_vld = 1'b0;
            end
            pfc_pkg::OP_KEY: begin
                if (key_done || ch > pfc_pkg::LET_LAST || ch == pfc_pkg::LET_J
                    || used_model[ch]) begin
                    acted = 1'b0;
                end else begin
                    add_to_square(ch);
                end
            end
            pfc_pkg::OP_FINISH: begin
                if (key_done) begin
                    acted = 1'b0;
                end else begin
                    for (int k = 0; k < pfc_pkg::ALPHA; k++) begin
                        if (k != pfc_pkg::LET_J && !used_model[k]) begin
                            add_to_square(pfc_pkg::letter_t'(k));
                        end
                    end
                    key_done = 1'b1;
                    held_vld = 1'b0;
                end
            end
            pfc_pkg::OP_TEXT: begin
                if (ch > pfc_pkg::LET_LAST) begin
                    acted = 1'b0;
                end else if (!key_done) begin
                    r0 = ERR_RESULT;
                    n = 1;
                end else begin
                    if (c == pfc_pkg::LET_J) begin
                        c = pfc_pkg::LET_I;
                    end
                    if (!held_vld) begin
                        held_let = c;
                        held_vld = 1'b1;
                    end else if (!dir_model && held_let == c) begin
                        // pad with x, keep the repeat held
                        map_pair(held_let, pfc_pkg::LET_X, r0, r1);
                        n = 2;
                    end else begin
                        map_pair(held_let, c, r0, r1);
                        held_vld = 1'b0;
                        n = 2;
                    end
                end
            end
            pfc_pkg::OP_END: begin
                if (!key_done || !held_vld) begin
                    acted = 1'b0;
                end else begin
                    held_vld = 1'b0;
                    if (dir_model) begin
                        r0 = ERR_RESULT;
                        n = 1;
                    end else begin
                        map_pair(held_let, pfc_pkg::LET_X, r0, r1);
                        n = 2;
                    end
                end
            end
            default: begin
                acted = 1'b0;
            end
        endcase
        return n;
    endfunction

    task automatic send_item(input logic [2:0] op, input pfc_pkg::letter_t ch);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_letter <= ch;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic feed(input logic [2:0] op, input pfc_pkg::letter_t ch);
        result_t r0, r1;
        logic acted;
        int n;
        send_item(op, ch);
        n = cipher_step(op, ch, r0, r1, acted);
        if (n > 0) cipher_q.push_back(r0);
        if (n > 1) cipher_q.push_back(r1);
        sent_items++;
        if (!acted) ignored_items++;
    endtask

    // drain, let the block settle, then write the direction register
    task automatic set_direction(input logic d);
        s_valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dir_model = d;
    endtask

    // one keyed message, or now and then a burst of noise
    task automatic run_message();
        int n_key, n_text;
        pfc_pkg::letter_t prev, ch;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 10)) begin
                feed(3'($urandom_range(7)), pfc_pkg::letter_t'($urandom_range(31)));
            end
            return;
        end
        feed(pfc_pkg::OP_CLEAR, pfc_pkg::letter_t'($urandom_range(31)));
        n_key = $urandom_range(14);
        repeat (n_key) begin
            if ($urandom_range(15) == 0) begin
                feed(pfc_pkg::OP_KEY, pfc_pkg::letter_t'($urandom_range(31)));
            end else begin
                feed(pfc_pkg::OP_KEY, pfc_pkg::letter_t'($urandom_range(25)));
            end
        end
        if ($urandom_range(9) == 0) begin
            feed(pfc_pkg::OP_TEXT, pfc_pkg::letter_t'($urandom_range(25)));
        end
        feed(pfc_pkg::OP_FINISH, pfc_pkg::letter_t'($urandom_range(31)));
        prev = pfc_pkg::letter_t'($urandom_range(25));
        n_text = $urandom_range(1, 24);
        repeat (n_text) begin
            case ($urandom_range(15))
                0, 1, 2: ch = prev;
                3:       ch = pfc_pkg::LET_X;
                4:       ch = pfc_pkg::LET_J;
                5:       ch = pfc_pkg::letter_t'($urandom_range(26, 31));
                default: ch = pfc_pkg::letter_t'($urandom_range(25));
            endcase
            if ($urandom_range(31) == 0) feed(pfc_pkg::OP_KEY, ch);
            else feed(pfc_pkg::OP_TEXT, ch);
            prev = ch;
        end
        if ($urandom_range(5) != 0) begin
            feed(pfc_pkg::OP_END, pfc_pkg::letter_t'($urandom_range(31)));
        end
    endtask

    initial begin : stimulus
        result_t r0, r1;
        logic acted;
        int n, goal, start_items;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_direction(1'b0);

        for (int i = 0; i < NUM_STEPS; i++) begin
            if (SCRIPT[i].dir != dir_model) set_direction(SCRIPT[i].dir);
            send_item(SCRIPT[i].op, SCRIPT[i].ch);
            n = cipher_step(SCRIPT[i].op, SCRIPT[i].ch, r0, r1, acted);
            if (SCRIPT[i].typed) begin
                if (SCRIPT[i].n_typed != 0) cipher_q.push_back(SCRIPT[i].r_typed);
            end else begin
                if (n > 0) cipher_q.push_back(r0);
                if (n > 1) cipher_q.push_back(r1);
            end
        end

        start_items = sent_items;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 18;
                    rx_idle_pct = 73;
                    hold_asked++;  // long receiver stall while the sender keeps offering
                end
                1: begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 18;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            goal = sent_items + RANDOM_ITEMS / 3;
            while (sent_items < goal) begin
                if ($urandom_range(3) == 0) set_direction(1'($urandom_range(1)));
                run_message();
            end
        end

        s_valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (cipher_q.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, cipher_q.size());
        end

        $display("covered %0d scripted and %0d random transactions (%0d had no effect)",
                 NUM_STEPS, sent_items - start_items, ignored_items);
        $display("checked %0d results in both directions: %0d pairs, %0d error results",
                 results_seen, pairs_seen, err_results);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (m_error === 1'b1) err_results++;
            else if (m_last === 1'b1) pairs_seen++;
            if (cipher_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: letter %0d last %0b error %0b",
                         $time, m_out_letter, m_last, m_error);
            end else begin
                head_r = cipher_q.pop_front();
                if (m_out_letter !== head_r.ch) begin
                    errors++;
                    $display("%0t: out_letter expected %0d, got %0d",
                             $time, head_r.ch, m_out_letter);
                end
                if (m_last !== head_r.last) begin
                    errors++;
                    $display("%0t: last expected %0b, got %0b", $time, head_r.last, m_last);
                end
                if (m_error !== head_r.err) begin
                    errors++;
                    $display("%0t: error expected %0b, got %0b", $time, head_r.err, m_error);
                end
            end
        end
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (hold_asked != hold_given) begin
            hold_given <= hold_given + 1;
            hold_cnt   <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet);
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

/* files.f */
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_pair_rule.sv
hw/rtl/playfair_digraph_cipher_unit.sv
tb/sv/testbench.sv
